/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// Every module that uses them has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFSU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TFSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfsu assertion failed");

`endif

/* rtl/core/tfsu_pkg.sv */
// ----------------------------------------------------------------------------
// tfsu_pkg
// Types, constants and codes shared by the thermal scale/upsample block.
// ----------------------------------------------------------------------------
`default_nettype none
package tfsu_pkg;

  localparam int SRC_WIDTH_DEF    = 160;
  localparam int SRC_HEIGHT_DEF   = 120;
  localparam int EDGE_WEIGHT_DEF  = 3;
  localparam int INNER_WEIGHT_DEF = 5;

  localparam int COORD_W = 11;
  localparam int NUM_W   = 24;
  localparam int DEN_W   = 16;
  localparam int QUO_W   = 8;
  localparam int ACC_W   = 13;
  localparam int WGT_W   = 4;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Reciprocal scaling for the interpolation weights: exact for every
  // ACC_W-bit sum and every divisor up to 32.
  localparam int RCP_SHIFT = 18;
  localparam int RCP_W     = 18;

  localparam logic [7:0] PIX_MAX = 8'hFF;

  typedef enum logic [2:0] {
    CFG_INTERP     = 3'd0,
    CFG_AGC        = 3'd1,
    CFG_MANUAL     = 3'd2,
    CFG_HIGH_RES   = 3'd3,
    CFG_MANUAL_MIN = 3'd4,
    CFG_MANUAL_MAX = 3'd5,
    CFG_FRAME_MIN  = 3'd6,
    CFG_FRAME_MAX  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        interp_enable;
    logic        agc_enable;
    logic        manual_range;
    logic        high_res;
    logic [15:0] manual_min;
    logic [15:0] manual_max;
    logic [15:0] frame_min;
    logic [15:0] frame_max;
  } cfg_t;

  typedef struct packed {
    logic        is_read;
    logic [7:0]  src_col;
    logic [6:0]  src_row;
    logic [15:0] pixel;
    logic [8:0]  out_col;
    logic [7:0]  out_row;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DV10,
    B_LIM,
    B_CHK,
    B_SAT,
    B_DIV,
    B_WR,
    B_RD,
    B_FETCH,
    B_ACC,
    B_SCL,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/core/tfsu_if.sv */
// ----------------------------------------------------------------------------
// tfsu_in_if / tfsu_out_if
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface tfsu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  src_col;
  logic [6:0]  src_row;
  logic [15:0] pixel;
  logic [8:0]  out_col;
  logic [7:0]  out_row;

  modport source (output valid, op, src_col, src_row, pixel, out_col, out_row,
                  input ready);
  modport sink   (input valid, op, src_col, src_row, pixel, out_col, out_row,
                  output ready);
endinterface

interface tfsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/thermal_frame_scale_upsample_top.sv */
// ----------------------------------------------------------------------------
// thermal_frame_scale_upsample_top
// Contrast stretch of thermal pixels into an 8-bit frame, read back at 2x.
// ----------------------------------------------------------------------------
// A write transfer (op = 0) converts a raw 16-bit pixel to 8 bits, either by
// keeping its low byte or by a linear stretch over a manual or frame range,
// and stores it in an on-chip frame of SRC_WIDTH x SRC_HEIGHT bytes. A read
// transfer (op = 1) returns one pixel of the doubled output image, either the
// owning source pixel or a weighted average of it and up to three neighbors.
// Items are taken into a two-entry queue and carried out one at a time by a
// sequencer that owns the frame memory. A write passes through the B_DV10,
// B_LIM and B_CHK states and then B_WR in the byte or clipped cases, adds
// B_SAT when the stretch saturates, and adds B_SAT and B_DIV for the full
// stretch, which divides with a one-bit-per-cycle divider. A read sets up
// its addresses in B_RD, fetches each pixel through the single memory port
// in B_FETCH and B_ACC, adds B_SCL for the weighted average when
// interpolating, and loads the result in B_OUT. Results leave through an
// output register, so the next item proceeds while a result still waits to
// be taken. The user must write the configuration registers through the cfg_
// port only while the block is idle; the block itself does not enforce this.
// The frame memory holds no reset value; reading a never-written pixel gives an arbitrary value.
`default_nettype none
module thermal_frame_scale_upsample_top
  import tfsu_pkg::*;
#(
  parameter int SRC_WIDTH    = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT   = SRC_HEIGHT_DEF,
  parameter int EDGE_WEIGHT  = EDGE_WEIGHT_DEF,
  parameter int INNER_WEIGHT = INNER_WEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tfsu_in_if.sink          in_ch,
  tfsu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_data;
  logic       ovalid_r;
  logic [7:0] odata_r;

  // Configuration registers; the register index selects which one a write
  // updates, and indexes with no register behind them are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{interp_enable: 1'b0, agc_enable: 1'b1, manual_range: 1'b0,
                 high_res: 1'b1, manual_min: 16'h0000, manual_max: 16'hFFFF,
                 frame_min: 16'h0000, frame_max: 16'hFFFF};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_INTERP:     cfg_r.interp_enable <= cfg_wdata[0];
        CFG_AGC:        cfg_r.agc_enable    <= cfg_wdata[0];
        CFG_MANUAL:     cfg_r.manual_range  <= cfg_wdata[0];
        CFG_HIGH_RES:   cfg_r.high_res      <= cfg_wdata[0];
        CFG_MANUAL_MIN: cfg_r.manual_min    <= cfg_wdata;
        CFG_MANUAL_MAX: cfg_r.manual_max    <= cfg_wdata;
        CFG_FRAME_MIN:  cfg_r.frame_min     <= cfg_wdata;
        CFG_FRAME_MAX:  cfg_r.frame_max     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: request acceptance and the queue toward the sequencer.
  tfsu_front #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // Back end: scaling, frame storage and upscaled reads.
  tfsu_back #(
    .SRC_WIDTH    (SRC_WIDTH),
    .SRC_HEIGHT   (SRC_HEIGHT),
    .EDGE_WEIGHT  (EDGE_WEIGHT),
    .INNER_WEIGHT (INNER_WEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .out_load (out_load),
    .out_data (out_data)
  );

  // Output register: a result may be loaded in the same cycle as the previous
  // one completes its transfer.
  assign out_free = !ovalid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= out_data;
    end
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.out_value = odata_r;

endmodule
`default_nettype wire

/* rtl/core/tfsu_div.sv */
// ----------------------------------------------------------------------------
// tfsu_div
// Restoring divider, one quotient bit per cycle; requires num < den * 256.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tfsu_div
  import tfsu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quot
);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-2:0] dsh_r;
  logic [QUO_W-1:0] q_r;
  logic [2:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             fit;

  assign fit  = rem_r >= {1'b0, dsh_r};
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, 7'd0};
      q_r   <= '0;
    end else if (busy_r) begin
      if (fit) begin
        rem_r <= rem_r - {1'b0, dsh_r};
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QUO_W-2:0], fit};
    end
  end

  `TFSU_ASSERT_NEXT(a_div_start_busy, start, busy_r)

endmodule
`default_nettype wire

/* rtl/core/tfsu_front.sv */
// ----------------------------------------------------------------------------
// tfsu_front
// Accepts request transfers, drops out-of-frame writes, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tfsu_front
  import tfsu_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tfsu_in_if.sink   in_ch,
  input  wire logic q_pop,
  output logic      q_valid,
  output item_t     q_item
);

  item_t      fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       take;
  logic       push;
  logic       in_frame;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign take        = in_ch.valid && in_ch.ready;
  assign in_frame    = ({3'd0, in_ch.src_col} < COORD_W'(SRC_WIDTH)) &&
                       ({4'd0, in_ch.src_row} < COORD_W'(SRC_HEIGHT));
  assign push        = take && (in_ch.op || in_frame);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{is_read: in_ch.op, src_col: in_ch.src_col,
                            src_row: in_ch.src_row, pixel: in_ch.pixel,
                            out_col: in_ch.out_col, out_row: in_ch.out_row};
    end
  end

  `TFSU_ASSERT_IMPLY(a_fifo_bound, 1'b1, cnt_r != 2'd3)
  `TFSU_ASSERT_IMPLY(a_pop_nonempty, q_pop, cnt_r != 2'd0)

endmodule
`default_nettype wire

/* rtl/core/tfsu_back.sv */
// ----------------------------------------------------------------------------
// tfsu_back
// Sequencer that scales and stores pixels and builds upscaled read results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tfsu_back
  import tfsu_pkg::*;
#(
  parameter int SRC_WIDTH    = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT   = SRC_HEIGHT_DEF,
  parameter int EDGE_WEIGHT  = EDGE_WEIGHT_DEF,
  parameter int INNER_WEIGHT = INNER_WEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  input  wire logic       out_free,
  output logic            out_load,
  output logic [7:0]      out_data
);

  localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SXW   = $clog2(SRC_WIDTH);
  localparam int SYW   = $clog2(SRC_HEIGHT);
  localparam logic [COORD_W-1:0] WLAST = COORD_W'(2 * SRC_WIDTH - 1);
  localparam logic [COORD_W-1:0] HLAST = COORD_W'(2 * SRC_HEIGHT - 1);
  localparam int EDGE_DEN  = EDGE_WEIGHT + 1;
  localparam int INNER_DEN = INNER_WEIGHT + 3;
  localparam int EDGE_MUL  = ((1 << RCP_SHIFT) + EDGE_DEN - 1) / EDGE_DEN;
  localparam int INNER_MUL = ((1 << RCP_SHIFT) + INNER_DEN - 1) / INNER_DEN;

  function automatic logic [AW-1:0] pix_addr(input logic [COORD_W-1:0] c,
                                             input logic [COORD_W-1:0] r);
    pix_addr = AW'(32'(r) * SRC_WIDTH + 32'(c));
  endfunction

  back_state_t state_r, state_nxt;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_r;
  item_t            item_r;
  logic [31:0]      plo_r, phi_r;
  logic [15:0]      lo_r, hi_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] d_r;
  logic [7:0]       val_r;
  logic [AW-1:0]    waddr_r;
  logic [AW-1:0]    addr_r [4];
  logic [1:0]       idx_r, last_r;
  logic [WGT_W-1:0] wgt_r;
  logic [ACC_W-1:0] acc_r;
  logic [RCP_W-1:0] mul_r;
  logic             copy_r;

  logic             div_start, div_done;
  logic [QUO_W-1:0] div_q;
  logic             mem_we;
  logic             chk_direct, sat;
  logic [15:0]      diff;
  logic [ACC_W+RCP_W-1:0] prod;

  // Read-side coordinate decode.
  logic [COORD_W-1:0] x, y, sx, sy, nx, ny;
  logic               xe, ye;

  always_comb begin
    x  = ({2'd0, item_r.out_col} > WLAST) ? WLAST : {2'd0, item_r.out_col};
    y  = ({3'd0, item_r.out_row} > HLAST) ? HLAST : {3'd0, item_r.out_row};
    sx = COORD_W'(SXW'(x >> 1));
    sy = COORD_W'(SYW'(y >> 1));
    nx = x[0] ? sx + COORD_W'(1) : sx - COORD_W'(1);
    ny = y[0] ? sy + COORD_W'(1) : sy - COORD_W'(1);
    xe = (x == '0) || (x == WLAST);
    ye = (y == '0) || (y == HLAST);
  end

  assign diff       = item_r.pixel - lo_r;
  assign chk_direct = cfg.agc_enable || (item_r.pixel < lo_r) || (hi_r <= lo_r);
  assign sat        = num_r >= {d_r, 8'd0};
  assign prod       = (ACC_W+RCP_W)'(acc_r) * (ACC_W+RCP_W)'(mul_r);
  assign out_data   = val_r;

  tfsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (d_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (q_valid) begin
        state_nxt = q_item.is_read ? B_RD : B_DV10;
      end
      B_DV10:  state_nxt = B_LIM;
      B_LIM:   state_nxt = B_CHK;
      B_CHK:   state_nxt = chk_direct ? B_WR : B_SAT;
      B_SAT:   if (sat) begin
        state_nxt = item_r.is_read ? B_OUT : B_WR;
      end else begin
        state_nxt = B_DIV;
      end
      B_DIV:   if (div_done) begin
        state_nxt = item_r.is_read ? B_OUT : B_WR;
      end
      B_WR:    state_nxt = B_IDLE;
      B_RD:    state_nxt = B_FETCH;
      B_FETCH: state_nxt = B_ACC;
      B_ACC:   if (idx_r != last_r) begin
        state_nxt = B_FETCH;
      end else begin
        state_nxt = copy_r ? B_OUT : B_SCL;
      end
      B_SCL:   state_nxt = B_OUT;
      B_OUT:   if (out_free) begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE:  q_pop     = q_valid;
      B_SAT:   div_start = !sat;
      B_WR:    mem_we    = 1'b1;
      B_OUT:   out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr_r] <= val_r;
    end
    rdata_r <= mem[addr_r[idx_r]];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        item_r <= q_item;
      end
      B_DV10: begin
        plo_r   <= cfg.manual_min * DIV10_MUL;
        phi_r   <= cfg.manual_max * DIV10_MUL;
        waddr_r <= pix_addr({3'd0, item_r.src_col}, {4'd0, item_r.src_row});
      end
      B_LIM: begin
        if (!cfg.manual_range) begin
          lo_r <= cfg.frame_min;
          hi_r <= cfg.frame_max;
        end else if (cfg.high_res) begin
          lo_r <= cfg.manual_min;
          hi_r <= cfg.manual_max;
        end else begin
          lo_r <= 16'(plo_r >> DIV10_SHIFT);
          hi_r <= 16'(phi_r >> DIV10_SHIFT);
        end
      end
      B_CHK: begin
        priority if (cfg.agc_enable) begin
          val_r <= item_r.pixel[7:0];
        end else if ((item_r.pixel < lo_r) || (hi_r < lo_r)) begin
          val_r <= '0;
        end else if (hi_r == lo_r) begin
          val_r <= PIX_MAX;
        end else begin
          num_r <= {diff, 8'd0} - {8'd0, diff};
          d_r   <= hi_r - lo_r;
        end
      end
      B_SAT: begin
        if (sat) begin
          val_r <= PIX_MAX;
        end
      end
      B_DIV: begin
        if (div_done) begin
          val_r <= div_q;
        end
      end
      B_RD: begin
        idx_r     <= 2'd0;
        addr_r[0] <= pix_addr(sx, sy);
        addr_r[1] <= ye ? pix_addr(nx, sy) : (xe ? pix_addr(sx, ny) : pix_addr(nx, sy));
        addr_r[2] <= pix_addr(sx, ny);
        addr_r[3] <= pix_addr(nx, ny);
        priority if (!cfg.interp_enable || (xe && ye)) begin
          copy_r <= 1'b1;
          last_r <= 2'd0;
          wgt_r  <= WGT_W'(1);
        end else if (xe || ye) begin
          copy_r <= 1'b0;
          last_r <= 2'd1;
          wgt_r  <= WGT_W'(EDGE_WEIGHT);
          mul_r  <= RCP_W'(EDGE_MUL);
        end else begin
          copy_r <= 1'b0;
          last_r <= 2'd3;
          wgt_r  <= WGT_W'(INNER_WEIGHT);
          mul_r  <= RCP_W'(INNER_MUL);
        end
      end
      B_ACC: begin
        if (idx_r == 2'd0) begin
          acc_r <= ACC_W'(wgt_r * rdata_r);
          val_r <= rdata_r;
        end else begin
          acc_r <= acc_r + ACC_W'(rdata_r);
        end
        idx_r <= idx_r + 2'd1;
      end
      B_SCL: begin
        val_r <= 8'(prod >> RCP_SHIFT);
      end
      default: ;
    endcase
  end

  `TFSU_ASSERT_IMPLY(a_div_done_in_div, div_done, state_r == B_DIV)

endmodule
`default_nettype wire
